// ===== design/gvae_pkg.sv =====
// shared types, widths and helpers for the gravity vector attitude estimator
// no dependencies; used by gvae_mul, gvae_sqdiv and the top level
package gvae_pkg;

    // field widths
    localparam int EstW   = 18;
    localparam int AccW   = 18;
    localparam int RateW  = 19;
    localparam int DtW    = 20;
    localparam int GainW  = 16;
    localparam int DeltaW = 31;

    // digit-serial multiplier geometry
    localparam int MulAW     = 32;
    localparam int MulBW     = 24;
    localparam int DigitW    = 4;
    localparam int MulSteps  = MulBW / DigitW;
    localparam int MulCntW   = 3;
    localparam int ProdW     = 56;

    // root and divide geometry
    localparam int RootInW = 36;
    localparam int RootW   = 18;
    localparam int DivNumW = 34;
    localparam int SdCntW  = 6;

    localparam logic signed [EstW-1:0] EstOne = 18'sd65536;
    localparam logic [1:0] AxisX = 2'd0;
    localparam logic [1:0] AxisZ = 2'd2;

    // reset values of the registers
    localparam logic [GainW-1:0] GainRst  = 16'd655;
    localparam logic [GainW-1:0] WinLoRst = 16'd3686;
    localparam logic [GainW-1:0] WinHiRst = 16'd4506;

    typedef enum logic [1:0] {
        REG_GAIN   = 2'd0,
        REG_WIN_LO = 2'd1,
        REG_WIN_HI = 2'd2,
        REG_NONE   = 2'd3
    } t_reg;

    // one multiply each, run in this order
    typedef enum logic [4:0] {
        OP_DR, OP_DP, OP_DY,
        OP_RZ1, OP_RX1, OP_RY1, OP_RZ2, OP_RX2, OP_RY2,
        OP_AX2, OP_AY2, OP_AZ2,
        OP_FX, OP_FY, OP_FZ,
        OP_EX2, OP_EY2, OP_EZ2,
        OP_VX, OP_VY, OP_VZ
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_ROOT_GO, ST_ROOT_WAIT,
        ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_sd_ctrl;

    // saturate a wide signed value to the estimate range
    function automatic logic signed [EstW-1:0] f_sat_est(input logic signed [39:0] v);
        logic signed [EstW-1:0] r;
        if (v > 40'sd131071) r = 18'sd131071;
        else if (v < -40'sd131072) r = -18'sd131072;
        else r = v[EstW-1:0];
        return r;
    endfunction

endpackage

// ===== design/gvae_mul.sv =====
// signed digit-serial multiplier, four multiplier bits per cycle
// depends on gvae_pkg
module gvae_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [gvae_pkg::MulAW-1:0]   i_a,
    input  logic signed [gvae_pkg::MulBW-1:0]   i_b,
    output logic                                o_done,
    output logic signed [gvae_pkg::ProdW-1:0]   o_prod
);
    logic                               r_busy;
    logic                               r_done;
    logic [gvae_pkg::MulCntW-1:0]       r_cnt;
    logic signed [gvae_pkg::MulAW-1:0]  r_a;
    logic signed [gvae_pkg::MulAW+5:0]  r_hi;
    logic [gvae_pkg::MulBW-1:0]         r_lo;

    logic                               last;
    logic signed [gvae_pkg::DigitW:0]   dsig;
    logic signed [gvae_pkg::MulAW+4:0]  pp;
    logic signed [gvae_pkg::MulAW+5:0]  sum;
    logic [gvae_pkg::MulAW+gvae_pkg::MulBW+5:0] full;

    // partial product of one digit, top digit taken as signed
    always_comb begin
        last = (r_cnt == gvae_pkg::MulCntW'(gvae_pkg::MulSteps - 1));
        dsig = last ? $signed({r_lo[gvae_pkg::DigitW-1], r_lo[gvae_pkg::DigitW-1:0]})
                    : $signed({1'b0, r_lo[gvae_pkg::DigitW-1:0]});
        pp   = r_a * dsig;
        sum  = r_hi + {pp[gvae_pkg::MulAW+4], pp};
        full = {r_hi, r_lo};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // accumulator shifts right one digit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum >>> gvae_pkg::DigitW;
            r_lo <= {sum[gvae_pkg::DigitW-1:0], r_lo[gvae_pkg::MulBW-1:gvae_pkg::DigitW]};
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(full[gvae_pkg::ProdW-1:0]);

    // a done pulse never repeats back to back
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done)
        else $error("multiplier done held");
    // start only arrives while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy)
        else $error("multiplier started while busy");
    // the step count is cleared when busy rises
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == '0)
        else $error("multiplier count not cleared");
endmodule

// ===== design/gvae_sqdiv.sv =====
// bit-serial integer square root (two radicand bits a cycle) and restoring divider
// depends on gvae_pkg
module gvae_sqdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gvae_pkg::t_sd_ctrl                i_ctrl,
    input  logic [gvae_pkg::RootInW-1:0]      i_num,
    input  logic [gvae_pkg::RootW-1:0]        i_den,
    output logic                              o_done,
    output logic [gvae_pkg::DivNumW-1:0]      o_res
);
    logic                            r_busy;
    logic                            r_done;
    logic                            r_div;
    logic [gvae_pkg::SdCntW-1:0]     r_cnt;
    logic [gvae_pkg::RootInW-1:0]    r_src;
    logic [gvae_pkg::RootW+1:0]      r_rem;
    logic [gvae_pkg::RootW-1:0]      r_root;
    logic [gvae_pkg::RootW-1:0]      r_den;

    logic [gvae_pkg::RootW+1:0]      rem_sq;
    logic [gvae_pkg::RootW+1:0]      trial;
    logic                            sq_ok;
    logic [gvae_pkg::RootW:0]        rem_dv;
    logic                            dv_ok;
    logic                            last;

    // one trial subtract per cycle
    always_comb begin
        rem_sq = {r_rem[gvae_pkg::RootW-1:0], r_src[gvae_pkg::RootInW-1 -: 2]};
        trial  = {r_root, 2'b01};
        sq_ok  = rem_sq >= trial;
        rem_dv = {r_rem[gvae_pkg::RootW-1:0], r_src[gvae_pkg::RootInW-1]};
        dv_ok  = rem_dv >= {1'b0, r_den};
        last   = r_div ? (r_cnt == gvae_pkg::SdCntW'(gvae_pkg::DivNumW - 1))
                       : (r_cnt == gvae_pkg::SdCntW'(gvae_pkg::RootW - 1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // shift datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_div  <= i_ctrl.is_div;
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
            r_src  <= i_ctrl.is_div ? {i_num[gvae_pkg::DivNumW-1:0], 2'b00} : i_num;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= dv_ok ? (gvae_pkg::RootW+2)'(rem_dv - {1'b0, r_den})
                               : (gvae_pkg::RootW+2)'(rem_dv);
                r_src <= {r_src[gvae_pkg::RootInW-2:0], dv_ok};
            end else begin
                r_rem  <= sq_ok ? (rem_sq - trial) : rem_sq;
                r_root <= {r_root[gvae_pkg::RootW-2:0], sq_ok};
                r_src  <= {r_src[gvae_pkg::RootInW-3:0], 2'b00};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_div ? r_src[gvae_pkg::DivNumW-1:0]
                          : {{(gvae_pkg::DivNumW-gvae_pkg::RootW){1'b0}}, r_root};

    // start only arrives while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_ctrl.start |-> !r_busy)
        else $error("root/divide started while busy");
    // done follows the last step
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy))
        else $error("root/divide done without work");
    // divide remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div && r_cnt != '0) |-> r_rem < {2'b00, r_den})
        else $error("divide remainder out of range");
endmodule

// ===== design/gravity_vector_attitude_estimator.sv =====
// gravity vector complementary filter: top level, sequencer and stream/APB ports
// depends on gvae_pkg, gvae_mul, gvae_sqdiv
//
// Keeps a unit down vector in Q1.16, reset to (0,0,1). An update request (tuser 0)
// rotates it by roll, pitch and yaw steps, pulls it toward the acceleration by the
// fusion gain when the squared acceleration lies inside the window, renormalizes it
// and reports it with the vertical acceleration; a project-only request (tuser 1)
// reports without changing it. One request is worked at a time, paced by the single
// shared multiplier (four bits a cycle, up to 21 products for an update, three for a
// project-only request), the root and up to three divides. A finished result waits
// in the output register while the next request is already taken. The user must
// write registers over APB only while no request is in flight; the block itself does
// not enforce it.
module gravity_vector_attitude_estimator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw, time_step, zero fill
    input  logic [135:0] s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // down_x, down_y, down_z, vertical_accel
    output logic [71:0]  m_axis_tdata,
    // accel_fused
    output logic         m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int EW = gvae_pkg::EstW;

    gvae_pkg::t_state r_state, n_state;
    gvae_pkg::t_op    r_op, n_op;
    logic [1:0]       r_axis, n_axis;

    logic [gvae_pkg::GainW-1:0] r_gain, r_win_lo, r_win_hi;
    logic signed [EW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;

    // request fields
    logic                               r_proj;
    logic signed [gvae_pkg::AccW-1:0]   r_ax, r_ay, r_az;
    logic signed [gvae_pkg::RateW-1:0]  r_rr, r_rp, r_ry;
    logic [gvae_pkg::DtW-1:0]           r_dt;

    logic signed [gvae_pkg::DeltaW-1:0] r_dr, r_dp, r_dy;
    logic [gvae_pkg::RootInW-1:0]       r_m2;
    logic signed [37:0]                 r_dot;
    logic [gvae_pkg::RootW-1:0]         r_mag;
    logic                               r_fused;

    logic                r_out_valid;
    logic signed [EW-1:0] r_ox, r_oy, r_oz, r_ova;
    logic                r_ofused;

    logic s_fire, m_fire, out_free, cfg_wr;

    logic                                mul_start, mul_done;
    logic signed [gvae_pkg::MulAW-1:0]   mul_a;
    logic signed [gvae_pkg::MulBW-1:0]   mul_b;
    logic signed [gvae_pkg::ProdW-1:0]   prod;

    gvae_pkg::t_sd_ctrl                  sd_ctrl;
    logic [gvae_pkg::RootInW-1:0]        sd_num;
    logic                                sd_done;
    logic [gvae_pkg::DivNumW-1:0]        sd_res;

    logic signed [gvae_pkg::AccW-1:0]    f_acc;
    logic signed [EW-1:0]                f_est;
    logic signed [22:0]                  f_diff;

    logic signed [gvae_pkg::ProdW-1:0]   rnd24, rnd16;
    logic signed [31:0]                  pr24;
    logic signed [23:0]                  pr16;
    logic [gvae_pkg::RootInW-1:0]        m2_sum;
    logic signed [37:0]                  dot_sum;
    logic                                in_win;
    logic signed [37:0]                  dot_rnd;

    logic signed [EW-1:0]                d_est;
    logic [EW-1:0]                       d_abs;
    logic [gvae_pkg::DivNumW-1:0]        d_num;
    logic signed [39:0]                  d_q;
    logic signed [EW-1:0]                d_val;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_fire   = m_axis_tvalid && m_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    gvae_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    gvae_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sd_ctrl),
        .i_num   (sd_num),
        .i_den   (r_mag),
        .o_done  (sd_done),
        .o_res   (sd_res)
    );

    // multiplier operands per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        f_acc = r_ax;
        f_est = r_x;
        case (r_op)
            gvae_pkg::OP_FY: begin f_acc = r_ay; f_est = r_y; end
            gvae_pkg::OP_FZ: begin f_acc = r_az; f_est = r_z; end
            default: ;
        endcase
        f_diff = 23'($signed({f_acc, 4'b0000})) - 23'(f_est);
        case (r_op)
            gvae_pkg::OP_DR:  begin mul_a = 32'(r_rr); mul_b = 24'(r_dt); end
            gvae_pkg::OP_DP:  begin mul_a = 32'(r_rp); mul_b = 24'(r_dt); end
            gvae_pkg::OP_DY:  begin mul_a = 32'(r_ry); mul_b = 24'(r_dt); end
            gvae_pkg::OP_RZ1: begin mul_a = 32'(r_dr); mul_b = 24'(r_x); end
            gvae_pkg::OP_RX1: begin mul_a = 32'(r_dr); mul_b = 24'(r_z); end
            gvae_pkg::OP_RY1: begin mul_a = 32'(r_dp); mul_b = 24'(r_z); end
            gvae_pkg::OP_RZ2: begin mul_a = 32'(r_dp); mul_b = 24'(r_y); end
            gvae_pkg::OP_RX2: begin mul_a = 32'(r_dy); mul_b = 24'(r_y); end
            gvae_pkg::OP_RY2: begin mul_a = 32'(r_dy); mul_b = 24'(r_x); end
            gvae_pkg::OP_AX2: begin mul_a = 32'(r_ax); mul_b = 24'(r_ax); end
            gvae_pkg::OP_AY2: begin mul_a = 32'(r_ay); mul_b = 24'(r_ay); end
            gvae_pkg::OP_AZ2: begin mul_a = 32'(r_az); mul_b = 24'(r_az); end
            gvae_pkg::OP_FX,
            gvae_pkg::OP_FY,
            gvae_pkg::OP_FZ:  begin mul_a = 32'(f_diff); mul_b = 24'(r_gain); end
            gvae_pkg::OP_EX2: begin mul_a = 32'(r_x); mul_b = 24'(r_x); end
            gvae_pkg::OP_EY2: begin mul_a = 32'(r_y); mul_b = 24'(r_y); end
            gvae_pkg::OP_EZ2: begin mul_a = 32'(r_z); mul_b = 24'(r_z); end
            gvae_pkg::OP_VX:  begin mul_a = 32'(r_x); mul_b = 24'(r_ax); end
            gvae_pkg::OP_VY:  begin mul_a = 32'(r_y); mul_b = 24'(r_ay); end
            gvae_pkg::OP_VZ:  begin mul_a = 32'(r_z); mul_b = 24'(r_az); end
            default: ;
        endcase
    end

    // product rounding, sums and window test
    always_comb begin
        rnd24   = (prod + 56'sd8388608) >>> 24;
        rnd16   = (prod + 56'sd32768) >>> 16;
        pr24    = rnd24[31:0];
        pr16    = rnd16[23:0];
        m2_sum  = r_m2 + prod[gvae_pkg::RootInW-1:0];
        dot_sum = r_dot + $signed(prod[37:0]);
        in_win  = (m2_sum >= {8'b0, r_win_lo, 12'b0}) && (m2_sum <= {8'b0, r_win_hi, 12'b0});
        dot_rnd = (r_dot + 38'sd32768) >>> 16;
    end

    // normalizing divide of the current axis
    always_comb begin
        case (r_axis)
            gvae_pkg::AxisX: d_est = r_x;
            gvae_pkg::AxisZ: d_est = r_z;
            default:         d_est = r_y;
        endcase
        d_abs = d_est[EW-1] ? EW'(-d_est) : EW'(d_est);
        d_num = gvae_pkg::DivNumW'({d_abs, 16'b0}) + gvae_pkg::DivNumW'(r_mag[gvae_pkg::RootW-1:1]);
        d_q   = d_est[EW-1] ? -$signed({6'b0, sd_res}) : $signed({6'b0, sd_res});
        d_val = gvae_pkg::f_sat_est(d_q);
        sd_num = (r_state == gvae_pkg::ST_DIV_GO) ? gvae_pkg::RootInW'(d_num) : r_m2;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_axis  = r_axis;
        case (r_state)
            gvae_pkg::ST_IDLE: begin
                if (s_fire) begin
                    n_op    = s_axis_tuser ? gvae_pkg::OP_VX : gvae_pkg::OP_DR;
                    n_state = gvae_pkg::ST_MUL_GO;
                end
            end
            gvae_pkg::ST_MUL_GO: n_state = gvae_pkg::ST_MUL_WAIT;
            gvae_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_op)
                        gvae_pkg::OP_AZ2: begin
                            n_op    = in_win ? gvae_pkg::OP_FX : gvae_pkg::OP_EX2;
                            n_state = gvae_pkg::ST_MUL_GO;
                        end
                        gvae_pkg::OP_EZ2: n_state = gvae_pkg::ST_ROOT_GO;
                        gvae_pkg::OP_VZ:  n_state = gvae_pkg::ST_OUT;
                        default: begin
                            n_op    = gvae_pkg::t_op'(r_op + 5'd1);
                            n_state = gvae_pkg::ST_MUL_GO;
                        end
                    endcase
                end
            end
            gvae_pkg::ST_ROOT_GO: n_state = gvae_pkg::ST_ROOT_WAIT;
            gvae_pkg::ST_ROOT_WAIT: begin
                if (sd_done) begin
                    if (sd_res == '0) begin
                        n_op    = gvae_pkg::OP_VX;
                        n_state = gvae_pkg::ST_MUL_GO;
                    end else begin
                        n_axis  = gvae_pkg::AxisX;
                        n_state = gvae_pkg::ST_DIV_GO;
                    end
                end
            end
            gvae_pkg::ST_DIV_GO: n_state = gvae_pkg::ST_DIV_WAIT;
            gvae_pkg::ST_DIV_WAIT: begin
                if (sd_done) begin
                    if (r_axis == gvae_pkg::AxisZ) begin
                        n_op    = gvae_pkg::OP_VX;
                        n_state = gvae_pkg::ST_MUL_GO;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = gvae_pkg::ST_DIV_GO;
                    end
                end
            end
            gvae_pkg::ST_OUT: if (out_free) n_state = gvae_pkg::ST_IDLE;
            default: n_state = gvae_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        s_axis_tready  = (r_state == gvae_pkg::ST_IDLE);
        mul_start      = (r_state == gvae_pkg::ST_MUL_GO);
        sd_ctrl.start  = (r_state == gvae_pkg::ST_ROOT_GO) || (r_state == gvae_pkg::ST_DIV_GO);
        sd_ctrl.is_div = (r_state == gvae_pkg::ST_DIV_GO);
    end

    // estimate updates
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (r_state == gvae_pkg::ST_MUL_WAIT && mul_done) begin
            case (r_op)
                gvae_pkg::OP_RZ1: n_z = gvae_pkg::f_sat_est(40'(r_z) - 40'(pr24));
                gvae_pkg::OP_RX1: n_x = gvae_pkg::f_sat_est(40'(r_x) + 40'(pr24));
                gvae_pkg::OP_RY1: n_y = gvae_pkg::f_sat_est(40'(r_y) + 40'(pr24));
                gvae_pkg::OP_RZ2: n_z = gvae_pkg::f_sat_est(40'(r_z) - 40'(pr24));
                gvae_pkg::OP_RX2: n_x = gvae_pkg::f_sat_est(40'(r_x) - 40'(pr24));
                gvae_pkg::OP_RY2: n_y = gvae_pkg::f_sat_est(40'(r_y) + 40'(pr24));
                gvae_pkg::OP_FX:  n_x = gvae_pkg::f_sat_est(40'(r_x) + 40'(pr16));
                gvae_pkg::OP_FY:  n_y = gvae_pkg::f_sat_est(40'(r_y) + 40'(pr16));
                gvae_pkg::OP_FZ:  n_z = gvae_pkg::f_sat_est(40'(r_z) + 40'(pr16));
                default: ;
            endcase
        end else if (r_state == gvae_pkg::ST_ROOT_WAIT && sd_done && sd_res == '0) begin
            n_x = '0;
            n_y = '0;
            n_z = gvae_pkg::EstOne;
        end else if (r_state == gvae_pkg::ST_DIV_WAIT && sd_done) begin
            case (r_axis)
                gvae_pkg::AxisX: n_x = d_val;
                gvae_pkg::AxisZ: n_z = d_val;
                default:         n_y = d_val;
            endcase
        end
    end

    // control state, estimate and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gvae_pkg::ST_IDLE;
            r_op        <= gvae_pkg::OP_DR;
            r_axis      <= gvae_pkg::AxisX;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= gvae_pkg::EstOne;
            r_gain      <= gvae_pkg::GainRst;
            r_win_lo    <= gvae_pkg::WinLoRst;
            r_win_hi    <= gvae_pkg::WinHiRst;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_axis  <= n_axis;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            if (r_state == gvae_pkg::ST_OUT && out_free) r_out_valid <= 1'b1;
            else if (m_fire) r_out_valid <= 1'b0;
            if (cfg_wr) begin
                case (gvae_pkg::t_reg'(paddr[3:2]))
                    gvae_pkg::REG_GAIN:   r_gain   <= pwdata[15:0];
                    gvae_pkg::REG_WIN_LO: r_win_lo <= pwdata[15:0];
                    gvae_pkg::REG_WIN_HI: r_win_hi <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_proj  <= s_axis_tuser;
            r_ax    <= $signed(s_axis_tdata[17:0]);
            r_ay    <= $signed(s_axis_tdata[35:18]);
            r_az    <= $signed(s_axis_tdata[53:36]);
            r_rr    <= $signed(s_axis_tdata[72:54]);
            r_rp    <= $signed(s_axis_tdata[91:73]);
            r_ry    <= $signed(s_axis_tdata[110:92]);
            r_dt    <= s_axis_tdata[130:111];
            r_m2    <= '0;
            r_dot   <= '0;
            r_fused <= 1'b0;
        end
        if (r_state == gvae_pkg::ST_MUL_WAIT && mul_done) begin
            case (r_op)
                gvae_pkg::OP_DR: r_dr <= $signed(prod[38:8]);
                gvae_pkg::OP_DP: r_dp <= $signed(prod[38:8]);
                gvae_pkg::OP_DY: r_dy <= $signed(prod[38:8]);
                gvae_pkg::OP_AX2, gvae_pkg::OP_AY2,
                gvae_pkg::OP_EX2, gvae_pkg::OP_EY2,
                gvae_pkg::OP_EZ2: r_m2 <= m2_sum;
                gvae_pkg::OP_AZ2: begin
                    r_fused <= in_win;
                    r_m2    <= '0;
                end
                gvae_pkg::OP_VX, gvae_pkg::OP_VY,
                gvae_pkg::OP_VZ: r_dot <= dot_sum;
                default: ;
            endcase
        end
        if (r_state == gvae_pkg::ST_ROOT_WAIT && sd_done) r_mag <= sd_res[gvae_pkg::RootW-1:0];
        if (r_state == gvae_pkg::ST_OUT && out_free) begin
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_oz     <= r_z;
            r_ova    <= gvae_pkg::f_sat_est(40'(dot_rnd));
            r_ofused <= r_fused && !r_proj;
        end
    end

    // register read
    always_comb begin
        case (gvae_pkg::t_reg'(paddr[3:2]))
            gvae_pkg::REG_GAIN:   prdata = {16'b0, r_gain};
            gvae_pkg::REG_WIN_LO: prdata = {16'b0, r_win_lo};
            gvae_pkg::REG_WIN_HI: prdata = {16'b0, r_win_hi};
            default:              prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_ova, r_oz, r_oy, r_ox};
    assign m_axis_tuser  = r_ofused;

    // idle holds without a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gvae_pkg::ST_IDLE && !s_fire) |=> r_state == gvae_pkg::ST_IDLE)
        else $error("left idle without a request");
    // a new result is loaded only from the output step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == gvae_pkg::ST_OUT)
        else $error("result valid raised outside output step");
    // multiplier answers only while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == gvae_pkg::ST_MUL_WAIT)
        else $error("product arrived while not waiting");
    // divide axis stays within x, y, z
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_axis != 2'd3)
        else $error("divide axis out of range");
endmodule

// ===== tb/sv/gvae_checker.sv =====
// result checker for the gravity vector attitude estimator
// watches the request, result and register channels, predicts results, counts mismatches
// depends on gvae_pkg
`timescale 1ns / 100ps

module gvae_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [135:0] i_req_data,
    input  logic         i_req_user,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [71:0]  i_res_data,
    input  logic         i_res_user,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int FracBits = 16;

    typedef struct {
        logic [gvae_pkg::EstW-1:0] dn_x;
        logic [gvae_pkg::EstW-1:0] dn_y;
        logic [gvae_pkg::EstW-1:0] dn_z;
        logic [gvae_pkg::AccW-1:0] vert;
        logic                      fused;
    } t_attitude;

    // predictor copy of registers and estimate
    longint gain_q, win_lo_q, win_hi_q;
    longint vec_x, vec_y, vec_z;
    t_attitude expected_q[$];

    assign o_pending = expected_q.size();

    function automatic longint floor_sh(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint round_sh(longint x, int s);
        if (s == 0) return x;
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint x, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint rotate_axis(longint tgt, longint ang, longint oth, bit neg);
        longint p;
        p = round_sh(ang * oth, 24);
        return clamp(neg ? tgt - p : tgt + p, gvae_pkg::EstW);
    endfunction

    function automatic longint int_root(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_div(longint c, longint mag);
        longint a, q;
        a = (c < 0) ? -c : c;
        q = ((a << FracBits) + (mag >> 1)) / mag;
        return clamp((c < 0) ? -q : q, gvae_pkg::EstW);
    endfunction

    function automatic longint pull_toward(longint e, longint acc);
        longint p;
        p = round_sh(gain_q * ((acc << (FracBits - 12)) - e), 16);
        return clamp(e + p, gvae_pkg::EstW);
    endfunction

    // advance the estimate (update requests only) and return the attitude report
    function automatic t_attitude predict_attitude(logic [135:0] d, logic proj_only);
        t_attitude r;
        longint ax, ay, az, dt, dr, dp, dy, m2, mag, dot;
        ax = longint'($signed(d[17:0]));
        ay = longint'($signed(d[35:18]));
        az = longint'($signed(d[53:36]));
        r.fused = 1'b0;
        if (!proj_only) begin
            dt = longint'(d[130:111]);
            dr = floor_sh(longint'($signed(d[72:54])) * dt, 8);
            dp = floor_sh(longint'($signed(d[91:73])) * dt, 8);
            dy = floor_sh(longint'($signed(d[110:92])) * dt, 8);
            vec_z = rotate_axis(vec_z, dr, vec_x, 1);
            vec_x = rotate_axis(vec_x, dr, vec_z, 0);
            vec_y = rotate_axis(vec_y, dp, vec_z, 0);
            vec_z = rotate_axis(vec_z, dp, vec_y, 1);
            vec_x = rotate_axis(vec_x, dy, vec_y, 1);
            vec_y = rotate_axis(vec_y, dy, vec_x, 0);
            m2 = ax * ax + ay * ay + az * az;
            if (m2 >= (win_lo_q << 12) && m2 <= (win_hi_q << 12)) begin
                r.fused = 1'b1;
                vec_x = pull_toward(vec_x, ax);
                vec_y = pull_toward(vec_y, ay);
                vec_z = pull_toward(vec_z, az);
            end
            mag = int_root(vec_x * vec_x + vec_y * vec_y + vec_z * vec_z);
            if (mag == 0) begin
                vec_x = 0;
                vec_y = 0;
                vec_z = longint'(1) << FracBits;
            end else begin
                vec_x = unit_div(vec_x, mag);
                vec_y = unit_div(vec_y, mag);
                vec_z = unit_div(vec_z, mag);
            end
        end
        dot = vec_x * ax + vec_y * ay + vec_z * az;
        r.dn_x = gvae_pkg::EstW'(clamp(vec_x, gvae_pkg::EstW));
        r.dn_y = gvae_pkg::EstW'(clamp(vec_y, gvae_pkg::EstW));
        r.dn_z = gvae_pkg::EstW'(clamp(vec_z, gvae_pkg::EstW));
        r.vert = gvae_pkg::AccW'(clamp(round_sh(dot, FracBits), gvae_pkg::AccW));
        return r;
    endfunction

    // track registers, predict on request, compare on result
    always @(posedge i_clk) begin
        t_attitude e;
        t_attitude a;
        if (!i_rst_n) begin
            gain_q   = longint'(gvae_pkg::GainRst);
            win_lo_q = longint'(gvae_pkg::WinLoRst);
            win_hi_q = longint'(gvae_pkg::WinHiRst);
            vec_x = 0;
            vec_y = 0;
            vec_z = longint'(1) << FracBits;
            o_fail_count = 0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (gvae_pkg::t_reg'(i_paddr[3:2]))
                    gvae_pkg::REG_GAIN:   gain_q   = longint'(i_pwdata[15:0]);
                    gvae_pkg::REG_WIN_LO: win_lo_q = longint'(i_pwdata[15:0]);
                    gvae_pkg::REG_WIN_HI: win_hi_q = longint'(i_pwdata[15:0]);
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_q.push_back(predict_attitude(i_req_data, i_req_user));
            if (i_res_valid && i_res_ready) begin
                a.dn_x  = i_res_data[17:0];
                a.dn_y  = i_res_data[35:18];
                a.dn_z  = i_res_data[53:36];
                a.vert  = i_res_data[71:54];
                a.fused = i_res_user;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $realtime, i_res_data, i_res_user);
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.dn_x !== a.dn_x) begin
                        $display("%0t: down_x exp %0d got %0d", $realtime,
                                 $signed(e.dn_x), $signed(a.dn_x));
                        o_fail_count++;
                    end
                    if (e.dn_y !== a.dn_y) begin
                        $display("%0t: down_y exp %0d got %0d", $realtime,
                                 $signed(e.dn_y), $signed(a.dn_y));
                        o_fail_count++;
                    end
                    if (e.dn_z !== a.dn_z) begin
                        $display("%0t: down_z exp %0d got %0d", $realtime,
                                 $signed(e.dn_z), $signed(a.dn_z));
                        o_fail_count++;
                    end
                    if (e.vert !== a.vert) begin
                        $display("%0t: vertical_accel exp %0d got %0d", $realtime,
                                 $signed(e.vert), $signed(a.vert));
                        o_fail_count++;
                    end
                    if (e.fused !== a.fused) begin
                        $display("%0t: accel_fused exp %b got %b", $realtime,
                                 e.fused, a.fused);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/gravity_vector_attitude_estimator_tb.sv =====
// testbench top for the gravity vector attitude estimator: clock, reset, stimulus, verdict
// depends on gvae_pkg, gvae_checker and the block under test
`timescale 1ns / 100ps

module gravity_vector_attitude_estimator_tb;

    localparam int IdleLimit = 20000;

    logic         i_clk;
    logic         i_rst_n;
    // accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw, time_step, zero fill
    logic [135:0] s_axis_tdata;
    // operation
    logic         s_axis_tuser;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // down_x, down_y, down_z, vertical_accel
    logic [71:0]  m_axis_tdata;
    // accel_fused
    logic         m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         psel, penable, pwrite, pready;
    logic [3:0]   paddr;
    logic [31:0]  pwdata, prdata;

    int  fail_count, pending;
    int  idle_cycles = 0;
    int  send_idle_pct, recv_stall_pct;
    bit  hold_off;

    gravity_vector_attitude_estimator i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    gvae_checker i_checker (
        .i_clk, .i_rst_n,
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_user(m_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stall, plus a long hold-off when asked
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("gravity_vector_attitude_estimator verification failed");
            $finish;
        end
    end

    task automatic reg_write(gvae_pkg::t_reg idx, logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // valid stays up after the accept until the next request or an idle cycle drops it
    task automatic send_request(logic op, logic [17:0] ax, logic [17:0] ay, logic [17:0] az,
                                logic [18:0] wr, logic [18:0] wp, logic [18:0] wy,
                                logic [19:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {5'b0, dt, wy, wp, wr, az, ay, ax};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // acceleration near one g, rates and steps mostly small
    task automatic send_random(int mode);
        logic [17:0] a[3];
        logic [18:0] w[3];
        logic [19:0] dt;
        for (int k = 0; k < 3; k++) begin
            if (mode < 6)
                a[k] = 18'($signed($urandom_range(0, 2400)) - 1200);
            else
                a[k] = 18'($urandom);
            w[k] = (mode < 8) ? 19'($signed($urandom_range(0, 40000)) - 20000) : 19'($urandom);
        end
        if (mode < 6)
            a[$urandom_range(2)] = ($urandom_range(1)) ? 18'sd4096 : -18'sd4096;
        dt = (mode < 8) ? 20'($urandom_range(0, 4000)) : 20'($urandom);
        send_request($urandom_range(9) == 0, a[0], a[1], a[2], w[0], w[1], w[2], dt);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tvalid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, both operations, zero step, window edges
        send_request(1'b1, 18'sd0, 18'sd0, 18'sd4096, '0, '0, '0, '0);
        send_request(1'b0, 18'sd0, 18'sd0, 18'sd4096, '0, '0, '0, '0);
        send_request(1'b0, 18'sd0, 18'sd0, 18'sd3840, 19'sd4096, '0, '0, 20'd1000);
        send_request(1'b0, 18'sd0, 18'sd0, 18'sd4296, '0, 19'sd4096, '0, 20'd1000);
        send_request(1'b0, 18'h1ffff, 18'h20000, 18'h1ffff, 19'h3ffff, 19'h40000,
                     19'h3ffff, 20'hfffff);
        send_request(1'b0, 18'h20000, 18'h20000, 18'h20000, 19'h40000, 19'h40000,
                     19'h40000, 20'hfffff);
        send_request(1'b1, 18'h1ffff, 18'h1ffff, 18'h1ffff, '0, '0, '0, '0);
        send_request(1'b1, 18'h20000, 18'h20000, 18'h20000, 19'h7ffff, 19'h7ffff,
                     19'h7ffff, 20'hfffff);
        send_request(1'b0, 18'sd4096, 18'sd0, 18'sd0, '0, '0, 19'h3ffff, 20'h80000);
        send_request(1'b0, '0, '0, '0, 19'h5555, 19'h2aaaa, 19'h15555, 20'haaaaa);
        drain();

        // full gain and an open window pull the estimate onto the acceleration, also a zero one
        reg_write(gvae_pkg::REG_GAIN, 16'hffff);
        reg_write(gvae_pkg::REG_WIN_LO, 16'h0000);
        reg_write(gvae_pkg::REG_WIN_HI, 16'hffff);
        send_request(1'b0, '0, '0, '0, '0, '0, '0, '0);
        send_request(1'b0, 18'sd4096, '0, '0, '0, '0, '0, '0);
        send_request(1'b0, 18'h1ffff, 18'h2aaaa, 18'h15555, 19'h2aaaa, 19'h55555,
                     19'h2aaaa, 20'h55555);
        drain();

        // random phases with varied registers and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            case (ph)
                0: begin
                    reg_write(gvae_pkg::REG_GAIN, 16'd655);
                    reg_write(gvae_pkg::REG_WIN_LO, 16'd3686);
                    reg_write(gvae_pkg::REG_WIN_HI, 16'd4506);
                end
                1: reg_write(gvae_pkg::REG_GAIN, 16'd0);
                2: begin
                    reg_write(gvae_pkg::REG_WIN_LO, 16'd5000);
                    reg_write(gvae_pkg::REG_WIN_HI, 16'd1000);
                end
                3: begin
                    reg_write(gvae_pkg::REG_GAIN, 16'(($urandom)));
                    reg_write(gvae_pkg::REG_WIN_LO, 16'd0);
                    reg_write(gvae_pkg::REG_WIN_HI, 16'hffff);
                end
                default: begin
                    reg_write(gvae_pkg::REG_GAIN, 16'($urandom_range(0, 20000)));
                    reg_write(gvae_pkg::REG_WIN_LO, 16'($urandom_range(2000, 4096)));
                    reg_write(gvae_pkg::REG_WIN_HI, 16'($urandom_range(4096, 9000)));
                end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (2000) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                    begin
                        repeat (10) send_random($urandom_range(9));
                        s_axis_tvalid <= 1'b0;
                        @(negedge i_clk);
                    end
                join
            end
            repeat (175) send_random($urandom_range(9));
            drain();
        end

        if (fail_count == 0)
            $display("gravity_vector_attitude_estimator verification clean");
        else
            $display("gravity_vector_attitude_estimator verification failed");
        $finish;
    end

endmodule
